@@ rtl/core/trhtc_pkg.sv @@
`default_nettype none
package trhtc_pkg;

    localparam int TableDepth = 32;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);
    localparam int CoordW     = 12;
    localparam int DistW      = 36;

    typedef enum logic [3:0] {
        MODE_BEGIN   = 4'd0,
        MODE_CLEAR   = 4'd1,
        MODE_MARK    = 4'd2,
        MODE_ADD     = 4'd3,
        MODE_ADDFULL = 4'd4,
        MODE_PUBLISH = 4'd5,
        MODE_HIT     = 4'd6,
        MODE_CAPTURE = 4'd7,
        MODE_UPDATE  = 4'd8,
        MODE_RELEASE = 4'd9,
        MODE_CANCEL  = 4'd10
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_FIND,
        ST_WALK,
        ST_CAPRD,
        ST_DONE
    } state_t;

    // one table entry
    typedef struct packed {
        logic [CoordW-1:0] left;
        logic [CoordW-1:0] top;
        logic [CoordW-1:0] right;
        logic [CoordW-1:0] bottom;
        logic [3:0]        kind;
        logic [31:0]       value;
        logic [7:0]        tap;
        logic [7:0]        hold;
    } entry_t;

    // containment test, touch point signed 16 bit
    function automatic logic contains(entry_t e, logic signed [15:0] x,
                                      logic signed [15:0] y);
        logic signed [16:0] xe;
        logic signed [16:0] ye;
        xe = 17'(x);
        ye = 17'(y);
        return (xe >= $signed({5'd0, e.left})) && (xe < $signed({5'd0, e.right}))
            && (ye >= $signed({5'd0, e.top})) && (ye < $signed({5'd0, e.bottom}));
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/touch_region_hit_test_capture.sv @@
`default_nettype none
// Touch region table with a staging and an active copy. Each input transfer
// carries one operation and gives one result transfer. Begin, clear, mark,
// add, add full screen, cancel and the spare modes go straight to the done
// state; update and release read the captured entry; publish copies one
// entry a cycle and then searches for the preserved capture one entry a
// cycle; hit test and capture walk the active table from the newest entry
// down through the shared distance unit, loading each entry and comparing
// the distance of an entry that contains the touch.
// s_tready is low while an operation is in progress and while a result waits
// for its transfer.
module touch_region_hit_test_capture
    import trhtc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mode, target_value, rect_left, rect_top, rect_right, rect_bottom,
    // target_kind, tap_event, hold_event, touch_x, touch_y, is_long_press
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // ok, hit_left, hit_top, hit_right, hit_bottom, hit_kind, hit_value,
    // hit_tap_event, hit_hold_event, has_targets, active_is_mapped,
    // staging_is_mapped
    output logic [111:0]      m_tdata
);
    localparam logic [2:0] AddrWidth  = 3'd0;
    localparam logic [2:0] AddrHeight = 3'd4;

    logic [CoordW-1:0] width_reg, height_reg;
    state_t            state_reg, state_next;

    // captured operation
    logic [3:0]         mode_reg;
    logic [31:0]        tval_reg;
    logic signed [15:0] x_reg, y_reg;
    logic               lp_reg;

    logic [CntW-1:0] scount_reg, acount_reg;
    logic [31:0]     sgen_reg, agen_reg;
    logic [1:0]      mapped_reg;
    logic [IdxW-1:0] cslot_reg;
    logic            cheld_reg;

    entry_t stab [TableDepth];
    entry_t atab [TableDepth];

    // walk state
    logic [CntW-1:0] idx_reg;
    logic            wphase_reg;
    logic            found_reg;
    logic [IdxW-1:0] best_reg;
    entry_t          best_ent_reg;
    logic [DistW-1:0] best_dist_reg;
    entry_t          rd_reg;
    logic            keep_reg;
    logic [3:0]      ck_reg;
    logic [31:0]     cv_reg;

    logic            ok_reg;
    entry_t          ret_reg;
    logic            ret_valid_reg;
    logic            outv_reg;
    entry_t          ret_out;

    logic [DistW-1:0] sq_dist;
    logic             cap_ok;

    assign pready   = 1'b1;
    assign prdata   = (paddr == AddrWidth) ? {20'd0, width_reg}
                    : (paddr == AddrHeight) ? {20'd0, height_reg} : 32'd0;
    assign s_tready = (state_reg == ST_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign cap_ok   = cheld_reg && ({1'b0, cslot_reg} < acount_reg);

    trhtc_dist u_dist
    (
        .ent     (rd_reg),
        .x       (x_reg),
        .y       (y_reg),
        .sq_dist (sq_dist)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CoordW'(320);
            height_reg <= CoordW'(240);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == AddrWidth)
                width_reg <= pwdata[CoordW-1:0];
            else if (paddr == AddrHeight)
                height_reg <= pwdata[CoordW-1:0];
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid && s_tready)
                begin
                    unique case (s_tdata[3:0])
                        MODE_PUBLISH: state_next = ST_COPY;
                        MODE_HIT, MODE_CAPTURE: state_next = ST_WALK;
                        MODE_UPDATE, MODE_RELEASE: state_next = ST_CAPRD;
                        default: state_next = ST_DONE;
                    endcase
                end
            ST_COPY:  if (idx_reg >= scount_reg) state_next = ST_FIND;
            ST_FIND:  if (!keep_reg || idx_reg >= acount_reg) state_next = ST_DONE;
            ST_WALK:  if (idx_reg == '0 && !wphase_reg) state_next = ST_DONE;
            ST_CAPRD: if (wphase_reg) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && scount_reg < CntW'(TableDepth)
            && (mode_reg == MODE_ADD || mode_reg == MODE_ADDFULL) && ok_reg)
            stab[scount_reg[IdxW-1:0]] <= ret_reg;
        if (state_reg == ST_COPY && idx_reg < scount_reg)
            atab[idx_reg[IdxW-1:0]] <= stab[idx_reg[IdxW-1:0]];
    end

    // operation datapath and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic signed [16:0] l, t, r, b;
        entry_t e;
        if (!rst_n)
        begin
            scount_reg    <= '0;
            acount_reg    <= '0;
            sgen_reg      <= '0;
            agen_reg      <= '0;
            mapped_reg    <= '0;
            cslot_reg     <= '0;
            cheld_reg     <= 1'b0;
            outv_reg      <= 1'b0;
            idx_reg       <= '0;
            wphase_reg    <= 1'b0;
            found_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            ret_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
        end
        else
        begin
            if (outv_reg && m_tready)
                outv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        mode_reg  <= s_tdata[3:0];
                        tval_reg  <= s_tdata[35:4];
                        x_reg     <= s_tdata[135:120];
                        y_reg     <= s_tdata[151:136];
                        lp_reg    <= s_tdata[152];
                        found_reg <= 1'b0;
                        wphase_reg <= 1'b0;
                        ret_valid_reg <= 1'b0;
                        ok_reg    <= 1'b0;
                        idx_reg   <= (s_tdata[3:0] == MODE_PUBLISH) ? '0 : acount_reg;
                        keep_reg  <= cap_ok && (agen_reg == sgen_reg);
                        ck_reg    <= atab[cslot_reg].kind;
                        cv_reg    <= atab[cslot_reg].value;
                        rd_reg    <= atab[cslot_reg];
                        // add: clip and prepare entry
                        if (s_tdata[3:0] == MODE_ADDFULL)
                        begin
                            l = '0; t = '0;
                            r = $signed({5'd0, width_reg});
                            b = $signed({5'd0, height_reg});
                        end
                        else
                        begin
                            l = 17'($signed(s_tdata[51:36]));
                            t = 17'($signed(s_tdata[67:52]));
                            r = 17'($signed(s_tdata[83:68]));
                            b = 17'($signed(s_tdata[99:84]));
                            if (l < 0) l = '0;
                            if (t < 0) t = '0;
                            if (r > $signed({5'd0, width_reg})) r = $signed({5'd0, width_reg});
                            if (b > $signed({5'd0, height_reg})) b = $signed({5'd0, height_reg});
                        end
                        e.left   = l[CoordW-1:0];
                        e.top    = t[CoordW-1:0];
                        e.right  = r[CoordW-1:0];
                        e.bottom = b[CoordW-1:0];
                        e.kind   = s_tdata[103:100];
                        e.value  = (s_tdata[3:0] == MODE_ADDFULL) ? 32'd0 : s_tdata[35:4];
                        e.tap    = s_tdata[111:104];
                        e.hold   = s_tdata[119:112];
                        ret_reg  <= e;
                        if (s_tdata[3:0] == MODE_ADD || s_tdata[3:0] == MODE_ADDFULL)
                            ok_reg <= (scount_reg < CntW'(TableDepth)) && (r > l) && (b > t);
                    end
                ST_COPY:
                    if (idx_reg < scount_reg)
                        idx_reg <= idx_reg + 1'b1;
                    else
                    begin
                        acount_reg <= scount_reg;
                        agen_reg   <= sgen_reg;
                        mapped_reg <= {mapped_reg[0], mapped_reg[0]};
                        cslot_reg  <= '0;
                        cheld_reg  <= 1'b0;
                        idx_reg    <= '0;
                        ok_reg     <= 1'b1;
                    end
                ST_FIND:
                    if (keep_reg && idx_reg < acount_reg)
                    begin
                        if (atab[idx_reg[IdxW-1:0]].kind == ck_reg
                            && atab[idx_reg[IdxW-1:0]].value == cv_reg)
                        begin
                            cslot_reg <= idx_reg[IdxW-1:0];
                            cheld_reg <= 1'b1;
                            keep_reg  <= 1'b0;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                ST_WALK:
                    // phase 0: load next entry; phase 1: compare its distance
                    if (!wphase_reg)
                    begin
                        if (idx_reg != '0)
                        begin
                            e = atab[idx_reg[IdxW-1:0] - 1'b1];
                            idx_reg <= idx_reg - 1'b1;
                            if (contains(e, x_reg, y_reg))
                            begin
                                if (!found_reg)
                                begin
                                    found_reg    <= 1'b1;
                                    best_reg     <= idx_reg[IdxW-1:0] - 1'b1;
                                    best_ent_reg <= e;
                                    rd_reg       <= e;
                                    wphase_reg   <= 1'b1;
                                    best_dist_reg <= '1;
                                end
                                else if (e.kind == best_ent_reg.kind)
                                begin
                                    rd_reg     <= e;
                                    best_reg   <= best_reg;
                                    wphase_reg <= 1'b1;
                                    ret_reg    <= e;
                                end
                            end
                        end
                    end
                    else
                    begin
                        wphase_reg <= 1'b0;
                        if (sq_dist < best_dist_reg)
                        begin
                            best_dist_reg <= sq_dist;
                            best_ent_reg  <= rd_reg;
                            best_reg      <= idx_reg[IdxW-1:0];
                        end
                    end
                ST_CAPRD:
                    wphase_reg <= 1'b1;
                ST_DONE:
                begin
                    outv_reg <= 1'b1;
                    unique case (mode_reg)
                        MODE_BEGIN:
                        begin
                            sgen_reg <= tval_reg; scount_reg <= '0;
                            mapped_reg[0] <= 1'b0; ok_reg <= 1'b1;
                        end
                        MODE_CLEAR:
                        begin
                            scount_reg <= '0; mapped_reg[0] <= 1'b0; ok_reg <= 1'b1;
                        end
                        MODE_MARK:
                        begin
                            mapped_reg[0] <= 1'b1; ok_reg <= 1'b1;
                        end
                        MODE_ADD, MODE_ADDFULL:
                            if (ok_reg)
                            begin
                                scount_reg <= scount_reg + 1'b1; mapped_reg[0] <= 1'b1;
                            end
                        MODE_PUBLISH: ok_reg <= 1'b1;
                        MODE_HIT:
                        begin
                            ok_reg <= found_reg; ret_valid_reg <= found_reg;
                            ret_reg <= best_ent_reg;
                        end
                        MODE_CAPTURE:
                        begin
                            ok_reg <= found_reg;
                            if (found_reg)
                            begin
                                cslot_reg <= best_reg; cheld_reg <= 1'b1;
                            end
                        end
                        MODE_UPDATE:
                            if (cap_ok)
                            begin
                                cheld_reg <= contains(rd_reg, x_reg, y_reg);
                                ok_reg    <= contains(rd_reg, x_reg, y_reg);
                            end
                        MODE_RELEASE:
                        begin
                            if (cap_ok && contains(rd_reg, x_reg, y_reg)
                                && (((lp_reg ? rd_reg.hold : rd_reg.tap) != 8'd0)
                                    || rd_reg.kind != 4'd0))
                            begin
                                ok_reg <= 1'b1; ret_valid_reg <= 1'b1; ret_reg <= rd_reg;
                            end
                            cslot_reg <= '0; cheld_reg <= 1'b0;
                        end
                        MODE_CANCEL:
                        begin
                            cslot_reg <= '0; cheld_reg <= 1'b0; ok_reg <= 1'b1;
                        end
                        default: ok_reg <= 1'b0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // result fields from the settled operation state, held while the result waits
    always_comb
    begin
        ret_out = ret_valid_reg ? ret_reg : '0;
        m_tdata = {8'd0, mapped_reg[0], mapped_reg[1], acount_reg != '0,
                   ret_out.hold, ret_out.tap, ret_out.value, ret_out.kind,
                   ret_out.bottom, ret_out.right, ret_out.top, ret_out.left, ok_reg};
    end

    // a waiting result blocks the input
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready);

    // a result stays offered and unchanged until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
                     m_tvalid && !m_tready |=> m_tvalid);
    assert property (@(posedge clk) disable iff (!rst_n)
                     m_tvalid && !m_tready |=> $stable(m_tdata));

    // input only taken while idle
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> state_reg == ST_IDLE);

    // table counts stay within the depth
    assert property (@(posedge clk) disable iff (!rst_n)
                     scount_reg <= CntW'(TableDepth) && acount_reg <= CntW'(TableDepth));
endmodule
`default_nettype wire

@@ rtl/core/trhtc_dist.sv @@
`default_nettype none
// doubled-centre squared distance of one entry
module trhtc_dist
    import trhtc_pkg::*;
(
    input  wire entry_t             ent,
    input  wire logic signed [15:0] x,
    input  wire logic signed [15:0] y,
    output logic [DistW-1:0]        sq_dist
);
    logic signed [17:0]      dx;
    logic signed [17:0]      dy;
    logic signed [DistW-1:0] sq_x;
    logic signed [DistW-1:0] sq_y;

    function automatic logic [CoordW:0] e_sum(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
        return {1'b0, a} + {1'b0, b};
    endfunction

    // centre offsets fit 18 bits, squares 35 bits
    always_comb
    begin
        dx = 18'($signed({x, 1'b0})) - $signed({5'd0, e_sum(ent.left, ent.right)});
        dy = 18'($signed({y, 1'b0})) - $signed({5'd0, e_sum(ent.top, ent.bottom)});
        sq_x = dx * dx;
        sq_y = dy * dy;
        sq_dist = $unsigned(sq_x) + $unsigned(sq_y);
    end
endmodule
`default_nettype wire
